### rtl/mstt_pkg.sv
// Shared types and constants for the timer slot table.
package mstt_pkg;

   localparam int TABLE_MAX   = 32;
   localparam int SLOT_FW     = 5;
   localparam int PERIOD_W    = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_CREATE  = 3'd1;
   localparam logic [2:0] CMD_SUSPEND = 3'd2;
   localparam logic [2:0] CMD_RESUME  = 3'd3;
   localparam logic [2:0] CMD_REMOVE  = 3'd4;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_TICK,
      OP_CREATE,
      OP_SUSPEND,
      OP_RESUME,
      OP_REMOVE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [2:0]          command;
      logic [SLOT_FW-1:0]  handle;
      logic [PERIOD_W-1:0] period;
      logic                periodic;
      logic                start_suspended;
   } req_type;

   typedef struct packed {
      logic [SLOT_FW-1:0] slot;
      logic               expired;
      logic               created;
      logic               table_full;
      logic               any_running;
      logic               last;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_FW-1:0]  handle;
      logic [PERIOD_W-1:0] period;
      logic                periodic;
      logic                start_suspended;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type item;
   } q_port_type;

endpackage

### rtl/mstt_front.sv
// Front end: accepts request beats and decodes them into work items.
module mstt_front #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mstt_pkg::req_type    req_data,
   input  logic                 q_full,
   output mstt_pkg::q_port_type q_push
);

   localparam logic [mstt_pkg::SLOT_FW:0] SLOT_LIMIT = (mstt_pkg::SLOT_FW + 1)'(SLOT_COUNT);

   logic           handle_ok;
   mstt_pkg::op_type op;

   assign handle_ok = {1'b0, req_data.handle} < SLOT_LIMIT;

   always_comb begin
      case (req_data.command)
         mstt_pkg::CMD_TICK:    op = mstt_pkg::OP_TICK;
         mstt_pkg::CMD_CREATE:  op = mstt_pkg::OP_CREATE;
         mstt_pkg::CMD_SUSPEND: op = handle_ok ? mstt_pkg::OP_SUSPEND : mstt_pkg::OP_NOP;
         mstt_pkg::CMD_RESUME:  op = handle_ok ? mstt_pkg::OP_RESUME : mstt_pkg::OP_NOP;
         mstt_pkg::CMD_REMOVE:  op = handle_ok ? mstt_pkg::OP_REMOVE : mstt_pkg::OP_NOP;
         default:               op = mstt_pkg::OP_NOP;
      endcase
   end

   assign req_stall                  = q_full;
   assign q_push.valid               = req_valid & ~q_full;
   assign q_push.item.op             = op;
   assign q_push.item.handle         = req_data.handle;
   assign q_push.item.period         = req_data.period;
   assign q_push.item.periodic       = req_data.periodic;
   assign q_push.item.start_suspended = req_data.start_suspended;

   // an accepted beat always lands in the queue
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> q_push.valid)
      else $error("accepted beat not pushed");

endmodule

### rtl/mstt_queue.sv
// Short work queue between the front end and the sweep engine.
module mstt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  mstt_pkg::q_port_type q_push,
   output logic                 q_full,
   output mstt_pkg::q_port_type q_head,
   input  logic                 q_pop
);

   localparam int CW = $clog2(mstt_pkg::QUEUE_DEPTH + 1);
   localparam int PW = $clog2(mstt_pkg::QUEUE_DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(mstt_pkg::QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_PTR   = PW'(mstt_pkg::QUEUE_DEPTH - 1);

   mstt_pkg::work_type entry_ff [mstt_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign q_full       = count_ff == FULL_COUNT;
   assign q_head.valid = count_ff != '0;
   assign q_head.item  = entry_ff[rd_ptr_ff];
   assign do_push      = q_push.valid & ~q_full;
   assign do_pop       = q_pop & q_head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count overflow");

endmodule

### rtl/mstt_back.sv
// Sweep engine: walks every slot per command, then delivers the result beats.
module mstt_back #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mstt_pkg::q_port_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mstt_pkg::rsp_type    rsp_data
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(SLOT_COUNT);
   localparam int PW = mstt_pkg::PERIOD_W;

   mstt_pkg::back_state_type state_ff, state_in;
   mstt_pkg::work_type       item_ff, item_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     proc_vld_ff, proc_vld_in;
   logic [SLOT_W-1:0]        proc_idx_ff, proc_idx_in;
   logic [SLOT_COUNT-1:0]    active_ff, active_in;
   logic [SLOT_COUNT-1:0]    running_ff, running_in;
   logic [SLOT_COUNT-1:0]    periodic_ff, periodic_in;
   logic [PW-1:0]            cd_rd_ff, rl_rd_ff;
   logic                     any_run_ff, any_run_in;
   logic                     found_ff, found_in;
   logic [SLOT_W-1:0]        found_idx_ff, found_idx_in;
   logic [SLOT_W-1:0]        exp_list_ff [SLOT_COUNT];
   logic [SLOT_W-1:0]        exp_list_in [SLOT_COUNT];
   logic [CNT_W-1:0]         nexp_ff, nexp_in;
   logic [CNT_W-1:0]         emit_ptr_ff, emit_ptr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mstt_pkg::rsp_type        rsp_ff, rsp_in;

   logic [PW-1:0] cd_mem [SLOT_COUNT];
   logic [PW-1:0] rl_mem [SLOT_COUNT];

   logic              issue_rd, emit_load, out_free, emit_last, has_exp;
   logic              cur_act, cur_run, cur_per, new_act, new_run, new_per;
   logic              cd_wr, rl_wr, expire;
   logic [PW-1:0]     cd_dec, cd_wdata;
   logic [SLOT_W-1:0] rd_addr;
   logic [CNT_W-1:0]  emit_next;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign has_exp   = (item_ff.op == mstt_pkg::OP_TICK) && (nexp_ff != '0);
   assign emit_next = emit_ptr_ff + CNT_W'(1);
   assign emit_last = ~has_exp | (emit_next == nexp_ff);
   assign rd_addr   = cnt_ff[SLOT_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mstt_pkg::ST_IDLE: begin
            if (q_head.valid) state_in = mstt_pkg::ST_SWEEP;
         end
         mstt_pkg::ST_SWEEP: begin
            if (cnt_ff == CNT_LIMIT) state_in = mstt_pkg::ST_EMIT;
         end
         mstt_pkg::ST_EMIT: begin
            if (out_free && emit_last) state_in = mstt_pkg::ST_IDLE;
         end
         default: state_in = mstt_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      issue_rd  = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         mstt_pkg::ST_IDLE:  q_pop     = q_head.valid;
         mstt_pkg::ST_SWEEP: issue_rd  = cnt_ff != CNT_LIMIT;
         mstt_pkg::ST_EMIT:  emit_load = out_free;
         default: ;
      endcase
   end

   // per-slot update for the slot whose memory read has returned
   always_comb begin
      cur_act  = active_ff[proc_idx_ff];
      cur_run  = running_ff[proc_idx_ff];
      cur_per  = periodic_ff[proc_idx_ff];
      new_act  = cur_act;
      new_run  = cur_run;
      new_per  = cur_per;
      cd_wr    = 1'b0;
      rl_wr    = 1'b0;
      expire   = 1'b0;
      cd_dec   = (cd_rd_ff != '0) ? cd_rd_ff - PW'(1) : cd_rd_ff;
      cd_wdata = cd_dec;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      if (proc_vld_ff) begin
         case (item_ff.op)
            mstt_pkg::OP_TICK: begin
               if (cur_act && cur_run) begin
                  cd_wr = 1'b1;
                  if (cd_dec == '0) begin
                     expire   = 1'b1;
                     cd_wdata = rl_rd_ff;
                     if (!cur_per) new_act = 1'b0;
                  end
               end
            end
            mstt_pkg::OP_CREATE: begin
               if (!found_ff && !cur_act) begin
                  new_act      = 1'b1;
                  new_run      = ~item_ff.start_suspended;
                  new_per      = item_ff.periodic;
                  cd_wr        = 1'b1;
                  rl_wr        = 1'b1;
                  cd_wdata     = item_ff.period;
                  found_in     = 1'b1;
                  found_idx_in = proc_idx_ff;
               end
            end
            mstt_pkg::OP_SUSPEND: begin
               if (item_ff.handle == mstt_pkg::SLOT_FW'(proc_idx_ff)) new_run = 1'b0;
            end
            mstt_pkg::OP_RESUME: begin
               if (item_ff.handle == mstt_pkg::SLOT_FW'(proc_idx_ff)) new_run = 1'b1;
            end
            mstt_pkg::OP_REMOVE: begin
               if (item_ff.handle == mstt_pkg::SLOT_FW'(proc_idx_ff)) new_act = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      proc_vld_in  = issue_rd;
      proc_idx_in  = rd_addr;
      active_in    = active_ff;
      running_in   = running_ff;
      periodic_in  = periodic_ff;
      any_run_in   = any_run_ff;
      exp_list_in  = exp_list_ff;
      nexp_in      = nexp_ff;
      emit_ptr_in  = emit_ptr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (q_pop) begin
         item_in     = q_head.item;
         cnt_in      = '0;
         any_run_in  = 1'b0;
         nexp_in     = '0;
         emit_ptr_in = '0;
      end
      if (issue_rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (proc_vld_ff) begin
         active_in[proc_idx_ff]   = new_act;
         running_in[proc_idx_ff]  = new_run;
         periodic_in[proc_idx_ff] = new_per;
         any_run_in = any_run_ff | (new_act & new_run);
         if (expire) begin
            exp_list_in[nexp_ff[SLOT_W-1:0]] = proc_idx_ff;
            nexp_in = nexp_ff + CNT_W'(1);
         end
      end
      if (emit_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.slot        = '0;
         rsp_in.expired     = 1'b0;
         rsp_in.created     = 1'b0;
         rsp_in.table_full  = 1'b0;
         rsp_in.any_running = any_run_ff;
         rsp_in.last        = emit_last;
         case (item_ff.op)
            mstt_pkg::OP_TICK: begin
               if (has_exp) begin
                  rsp_in.slot    = mstt_pkg::SLOT_FW'(exp_list_ff[emit_ptr_ff[SLOT_W-1:0]]);
                  rsp_in.expired = 1'b1;
                  emit_ptr_in    = emit_next;
               end
            end
            mstt_pkg::OP_CREATE: begin
               if (found_ff) begin
                  rsp_in.slot    = mstt_pkg::SLOT_FW'(found_idx_ff);
                  rsp_in.created = 1'b1;
               end else begin
                  rsp_in.table_full = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mstt_pkg::ST_IDLE;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         running_ff   <= '0;
         periodic_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         running_ff   <= running_in;
         periodic_ff  <= periodic_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      cnt_ff       <= cnt_in;
      proc_idx_ff  <= proc_idx_in;
      any_run_ff   <= any_run_in;
      exp_list_ff  <= exp_list_in;
      nexp_ff      <= nexp_in;
      emit_ptr_ff  <= emit_ptr_in;
      rsp_ff       <= rsp_in;
      if (q_pop) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      found_idx_ff <= found_idx_in;
   end

   // countdown and reload memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cd_wr) begin
         cd_mem[proc_idx_ff] <= cd_wdata;
      end
      if (rl_wr) begin
         rl_mem[proc_idx_ff] <= item_ff.period;
      end
      if (issue_rd) begin
         cd_rd_ff <= cd_mem[rd_addr];
         rl_rd_ff <= rl_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_nexp_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mstt_pkg::ST_EMIT) |-> (nexp_ff <= CNT_LIMIT))
      else $error("expiry count beyond slot count");

   a_emit_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mstt_pkg::ST_EMIT && has_exp) |-> (emit_ptr_ff < nexp_ff))
      else $error("expiry walk past end of list");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.expired) |-> (!rsp_ff.created && !rsp_ff.table_full))
      else $error("expiry beat mixed with create status");

endmodule

### rtl/multi_slot_timer_table.sv
// Timer slot table top level: front decode, work queue and sweep engine.
// Each command walks every slot, one per cycle, through the countdown/reload memories;
// the engine then emits one result beat, or one per expiry for a tick with expiries.
// The queue lets new requests be accepted while the engine still works on an item.
// A request is accepted at the first edge at which the queue has room.
// Reset clears all slot marks, the queue and the engine; memories hold no reset.
module multi_slot_timer_table #(
   parameter int NUM_SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mstt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mstt_pkg::rsp_type rsp_data
);

   localparam int SLOT_COUNT = (NUM_SLOTS < mstt_pkg::TABLE_MAX) ? NUM_SLOTS
                                                                 : mstt_pkg::TABLE_MAX;

   mstt_pkg::q_port_type q_push;
   mstt_pkg::q_port_type q_head;
   logic                 q_full;
   logic                 q_pop;

   mstt_front #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   mstt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   mstt_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
